FILE: rtl/move_to_front_session_cache_assert.svh
// ----------------------------------------------------------------------------
// move_to_front_session_cache_assert.svh
// Assertion macros for the session cache. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_SESSION_CACHE_ASSERT_SVH
`define MOVE_TO_FRONT_SESSION_CACHE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define MTFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("session cache check failed");

// antecedent implies consequent in the next cycle
`define MTFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("session cache check failed");

// condition holds at every edge
`define MTFC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("session cache check failed");

`else

`define MTFC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MTFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`define MTFC_ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

FILE: rtl/mtfc_pkg.sv
// ----------------------------------------------------------------------------
// mtfc_pkg
// Beat types, opcodes and controller/datapath interface for the session cache.
// ----------------------------------------------------------------------------
package mtfc_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_STORE  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value_out;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request, restart scan
      logic scan;        // scan step
      logic write_val;   // overwrite value of the matching slot
      logic shift_load;  // set up the shift pointer
      logic shift;       // shift step
      logic front;       // write slot 0
      logic rsp_load;    // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic store;       // captured request is a store
      logic match;       // key compare hit this cycle
      logic scan_end;    // all valid slots compared, no hit
      logic shift_done;  // all moves written
   } status_type;

endpackage

FILE: rtl/mtfc_ram.sv
// ----------------------------------------------------------------------------
// mtfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mtfc_datapath.sv
// ----------------------------------------------------------------------------
// mtfc_datapath
// Entry RAMs, pipelined key scan, slot shifter, entry count and result register.
// ----------------------------------------------------------------------------
module mtfc_datapath #(
   parameter int ENTRIES = 32,
   localparam int IDX_W = $clog2(ENTRIES),
   localparam int CNT_W = $clog2(ENTRIES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mtfc_pkg::req_type    req_item,
   input  mtfc_pkg::cmd_type    cmd,
   output mtfc_pkg::status_type status,
   output mtfc_pkg::rsp_type    rsp_item
);

   // captured request and result
   mtfc_pkg::req_type req_ff;
   mtfc_pkg::rsp_type rsp_ff, rsp_in;

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             cmp_pend_ff, cmp_pend_in;
   logic             wr_pend_ff, wr_pend_in;
   logic             found_ff, found_in;

   // pointers and hit capture
   logic [CNT_W-1:0]            scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]            cmp_ptr_ff, cmp_ptr_in;
   logic [IDX_W-1:0]            sh_ptr_ff, sh_ptr_in;
   logic [IDX_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]            hit_pos_ff, hit_pos_in;
   logic [mtfc_pkg::VALUE_W-1:0] hit_value_ff, hit_value_in;

   // RAM ports
   logic [IDX_W-1:0]             rd_addr;
   logic [mtfc_pkg::KEY_W-1:0]   key_rd, key_wdata;
   logic [mtfc_pkg::VALUE_W-1:0] val_rd, val_wdata;
   logic                         key_we, val_we;
   logic [IDX_W-1:0]             key_waddr, val_waddr;

   logic             is_store;
   logic             match;
   logic             scan_issue;
   logic             move_wr;
   logic [IDX_W-1:0] last_slot;

   assign is_store   = (req_ff.opcode == mtfc_pkg::OP_STORE);
   assign match      = cmp_pend_ff && (key_rd == req_ff.key);
   assign scan_issue = (scan_ptr_ff < count_ff);
   assign move_wr    = cmd.shift && wr_pend_ff;

   // highest slot a new entry pushes into; a full cache drops its last slot
   assign last_slot = (count_ff == CNT_W'(ENTRIES)) ? IDX_W'(ENTRIES - 1)
                                                    : count_ff[IDX_W-1:0];

   assign status.store      = is_store;
   assign status.match      = match;
   assign status.scan_end   = !cmp_pend_ff && !scan_issue;
   assign status.shift_done = (sh_ptr_ff == '0) && !wr_pend_ff;

   // one shared read address: scan walks up, shift reads the slot below
   assign rd_addr = cmd.shift ? (sh_ptr_ff - IDX_W'(1)) : scan_ptr_ff[IDX_W-1:0];

   // write muxes
   always_comb begin
      key_we    = move_wr || cmd.front;
      key_waddr = cmd.front ? '0 : wr_ptr_ff;
      key_wdata = cmd.front ? req_ff.key : key_rd;

      val_we    = move_wr || cmd.front || cmd.write_val;
      val_waddr = wr_ptr_ff;
      val_wdata = val_rd;
      if (cmd.front) begin
         val_waddr = '0;
         val_wdata = is_store ? req_ff.value_in : hit_value_ff;
      end else if (cmd.write_val) begin
         val_waddr = hit_pos_ff;
         val_wdata = req_ff.value_in;
      end
   end

   mtfc_ram #(
      .WIDTH (mtfc_pkg::KEY_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   mtfc_ram #(
      .WIDTH (mtfc_pkg::VALUE_W),
      .DEPTH (ENTRIES)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   // next-state logic for pointers, flags and count
   always_comb begin
      count_in     = count_ff;
      cmp_pend_in  = cmp_pend_ff;
      wr_pend_in   = wr_pend_ff;
      found_in     = found_ff;
      scan_ptr_in  = scan_ptr_ff;
      cmp_ptr_in   = cmp_ptr_ff;
      sh_ptr_in    = sh_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      hit_pos_in   = hit_pos_ff;
      hit_value_in = hit_value_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         scan_ptr_in = '0;
         cmp_pend_in = 1'b0;
         wr_pend_in  = 1'b0;
         found_in    = 1'b0;
      end

      // scan: issue next slot, compare the one issued last cycle
      if (cmd.scan) begin
         cmp_pend_in = scan_issue;
         cmp_ptr_in  = scan_ptr_ff[IDX_W-1:0];
         if (scan_issue) begin
            scan_ptr_in = scan_ptr_ff + CNT_W'(1);
         end
         if (match) begin
            found_in     = 1'b1;
            hit_pos_in   = cmp_ptr_ff;
            hit_value_in = val_rd;
         end
      end

      if (cmd.shift_load) begin
         sh_ptr_in  = match ? cmp_ptr_ff : last_slot;
         wr_pend_in = 1'b0;
      end

      // shift: read slot sh_ptr-1, write it to sh_ptr in the next cycle
      if (cmd.shift) begin
         wr_pend_in = (sh_ptr_ff != '0);
         wr_ptr_in  = sh_ptr_ff;
         if (sh_ptr_ff != '0) begin
            sh_ptr_in = sh_ptr_ff - IDX_W'(1);
         end
      end

      if (cmd.front && is_store && (count_ff != CNT_W'(ENTRIES))) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.rsp_load) begin
         rsp_in.hit       = found_ff;
         rsp_in.value_out = (found_ff && !is_store) ? hit_value_ff : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         cmp_pend_ff <= 1'b0;
         wr_pend_ff  <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         count_ff    <= count_in;
         cmp_pend_ff <= cmp_pend_in;
         wr_pend_ff  <= wr_pend_in;
         found_ff    <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      scan_ptr_ff  <= scan_ptr_in;
      cmp_ptr_ff   <= cmp_ptr_in;
      sh_ptr_ff    <= sh_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      hit_pos_ff   <= hit_pos_in;
      hit_value_ff <= hit_value_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

FILE: rtl/mtfc_ctrl.sv
// ----------------------------------------------------------------------------
// mtfc_ctrl
// Sequencer for one request: scan, in-place update or shift, front write, result.
// ----------------------------------------------------------------------------
module mtfc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mtfc_pkg::status_type status,
   output mtfc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SHIFT,
      ST_FRONT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.match) begin
               if (status.store) begin
                  state_in = ST_UPDATE;
               end else begin
                  cmd.shift_load = 1'b1;
                  state_in       = ST_SHIFT;
               end
            end else if (status.scan_end) begin
               if (status.store) begin
                  cmd.shift_load = 1'b1;
                  state_in       = ST_SHIFT;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_UPDATE: begin
            cmd.write_val = 1'b1;
            state_in      = ST_RESP;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_done) begin
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            cmd.front = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/move_to_front_session_cache.sv
// ----------------------------------------------------------------------------
// move_to_front_session_cache: recency-ordered key/value cache, one beat at a time.
// Lookup hits move to the front, stores to a known key overwrite in place, and new keys
// insert at the front, evicting the last slot when full. Scan and shift share one read
// port of the entry RAMs.
// The next beat is accepted in the cycle after a result loads, also while it waits.
// Reset clears the entry count and control only; entry RAMs need no clearing pass.
// ----------------------------------------------------------------------------
`include "move_to_front_session_cache_assert.svh"

module move_to_front_session_cache #(
   parameter int ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mtfc_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtfc_pkg::rsp_type rsp_item
);

   mtfc_pkg::cmd_type    cmd;
   mtfc_pkg::status_type status;
   logic [5:0]           step_cmds;

   mtfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mtfc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // datapath steps that must never overlap
   assign step_cmds = {cmd.load, cmd.scan, cmd.write_val, cmd.shift, cmd.front, cmd.rsp_load};

   // an accepted beat keeps the sequencer busy next cycle
   `MTFC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a pending result is never overwritten
   `MTFC_ASSERT_IMPLY(a_no_rsp_overwrite, clock, reset, cmd.rsp_load, !rsp_valid || rsp_ready)

   // at most one datapath step per cycle
   `MTFC_ASSERT_ALWAYS(a_one_step, clock, reset, $onehot0(step_cmds))

endmodule

FILE: test/move_to_front_session_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// move_to_front_session_cache_tb
// Self-checking bench for the recency-ordered session cache. A short table
// of directed beats covers the empty cache, extreme keys and values, hits,
// misses and in-place overwrites. Random traffic follows: hits on live
// entries, stores over a key pool larger than the cache, and floods of
// fresh keys that force evictions. Every result beat is compared with a hand-typed
// expectation or an in-bench model of the cache while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module move_to_front_session_cache_tb;

   localparam int CACHE_DEPTH = 32;
   localparam int POOL_SIZE   = 40;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 80;
   localparam int CYCLE_LIMIT = 1000000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mtfc_pkg::req_type req_item  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mtfc_pkg::rsp_type rsp_item;

   // directed beat, with an optional hand-typed expectation
   typedef struct {
      mtfc_pkg::req_type req;
      bit                typed;
      mtfc_pkg::rsp_type want;
   } probe_row_type;

   probe_row_type     probe_table[$];
   mtfc_pkg::rsp_type expected_q[$];

   // shadow copy of the cache, front entry in slot 0
   logic [mtfc_pkg::KEY_W-1:0]   shadow_key[CACHE_DEPTH];
   logic [mtfc_pkg::VALUE_W-1:0] shadow_val[CACHE_DEPTH];
   int                           shadow_count = 0;
   logic [mtfc_pkg::KEY_W-1:0]   key_pool[POOL_SIZE];

   int   req_idle_pct  = 0;
   int   rsp_idle_pct  = 0;
   logic hold_ask      = 1'b0;
   int   stall_left    = 0;
   int   flood_left    = 0;
   int   cycle_count   = 0;
   int   error_count   = 0;
   int   beats_sent    = 0;
   int   results_seen  = 0;
   int   hits_seen     = 0;
   int   evictions     = 0;

   move_to_front_session_cache #(
      .ENTRIES(CACHE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request to the shadow cache and return the result it causes.
   function automatic mtfc_pkg::rsp_type cache_apply(input mtfc_pkg::req_type r);
      mtfc_pkg::rsp_type            res;
      int                           pos;
      int                           i;
      logic [mtfc_pkg::KEY_W-1:0]   k;
      logic [mtfc_pkg::VALUE_W-1:0] v;
      res = '0;
      pos = -1;
      for (i = 0; i < shadow_count; i++) begin
         if (pos < 0 && shadow_key[i] == r.key) pos = i;
      end
      if (r.opcode == mtfc_pkg::OP_LOOKUP) begin
         // hit: promote to the front; miss leaves the cache alone
         if (pos >= 0) begin
            k = shadow_key[pos];
            v = shadow_val[pos];
            for (i = pos; i > 0; i--) begin
               shadow_key[i] = shadow_key[i-1];
               shadow_val[i] = shadow_val[i-1];
            end
            shadow_key[0] = k;
            shadow_val[0] = v;
            res.hit       = 1'b1;
            res.value_out = v;
         end
      end else if (pos >= 0) begin
         // known key: overwrite in place, no move
         shadow_val[pos] = r.value_in;
         res.hit         = 1'b1;
      end else begin
         // new key: drop the oldest when full, then insert at the front
         if (shadow_count >= CACHE_DEPTH) begin
            shadow_count = CACHE_DEPTH - 1;
            evictions++;
         end
         for (i = shadow_count; i > 0; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_val[i] = shadow_val[i-1];
         end
         shadow_key[0] = r.key;
         shadow_val[0] = r.value_in;
         shadow_count++;
      end
      return res;
   endfunction

   function automatic void add_row(input mtfc_pkg::opcode_type op,
                                   input logic [mtfc_pkg::KEY_W-1:0] k,
                                   input logic [mtfc_pkg::VALUE_W-1:0] v, input bit typed,
                                   input logic hit,
                                   input logic [mtfc_pkg::VALUE_W-1:0] vout);
      probe_row_type row;
      row.req.opcode      = op;
      row.req.key         = k;
      row.req.value_in    = v;
      row.typed           = typed;
      row.want.hit        = hit;
      row.want.value_out  = vout;
      probe_table.push_back(row);
   endfunction

   // Random request: mostly live-key hits and pool traffic, now and then a
   // flood of fresh keys that pushes the cache into eviction.
   function automatic mtfc_pkg::req_type random_req();
      mtfc_pkg::req_type r;
      int                pick;
      r.value_in = $urandom();
      r.opcode   = mtfc_pkg::opcode_type'($urandom_range(1));
      if (flood_left > 0) begin
         flood_left--;
         r.opcode = mtfc_pkg::OP_STORE;
         r.key    = $urandom();
         return r;
      end
      if ($urandom_range(999) < 5) flood_left = CACHE_DEPTH + 2;
      pick = $urandom_range(99);
      if (pick < 35 && shadow_count > 0) begin
         r.opcode = mtfc_pkg::OP_LOOKUP;
         r.key    = shadow_key[$urandom_range(shadow_count - 1)];
      end else if (pick < 50 && shadow_count > 0) begin
         r.opcode = mtfc_pkg::OP_STORE;
         r.key    = shadow_key[$urandom_range(shadow_count - 1)];
      end else if (pick < 88) begin
         r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
         r.key = $urandom();
      end
      return r;
   endfunction

   // Offer one beat after a random idle gap; record its expectation on accept.
   task automatic send_beat(input mtfc_pkg::req_type r, input bit typed,
                            input mtfc_pkg::rsp_type want);
      int                gap;
      mtfc_pkg::rsp_type model_res;
      gap = 0;
      while (gap < 200 && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!req_ready);
      model_res = cache_apply(r);
      expected_q.push_back(typed ? want : model_res);
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Result side: random or long stalls, and checking of each result beat.
   always @(posedge clock) begin
      mtfc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_item.hit) hits_seen++;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: hit %0d value_out %h",
                   rsp_item.hit, rsp_item.value_out);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_item.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_item.hit);
               error_count++;
            end
            if (rsp_item.value_out !== want.value_out) begin
               $error("value_out: expected %h, got %h", want.value_out, rsp_item.value_out);
               error_count++;
            end
         end
      end
      if (hold_ask) stall_left = LONG_HOLD;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out with %0d results still expected.", expected_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus.
   initial begin
      int i;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

      // empty cache, extreme keys and values, overwrite, misses
      add_row(mtfc_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b0, 32'h0000_0000);
      add_row(mtfc_pkg::OP_STORE,  32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b0, 32'h0000_0000);
      add_row(mtfc_pkg::OP_STORE,  32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0, 32'h0000_0000);
      add_row(mtfc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF);
      add_row(mtfc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'h0000_0000);
      add_row(mtfc_pkg::OP_STORE,  32'hFFFF_FFFF, 32'h1234_5678, 1, 1'b1, 32'h0000_0000);
      add_row(mtfc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'h1234_5678);
      add_row(mtfc_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0000, 1, 1'b0, 32'h0000_0000);
      add_row(mtfc_pkg::OP_STORE,  32'hAAAA_AAAA, 32'h5555_5555, 1, 1'b0, 32'h0000_0000);
      add_row(mtfc_pkg::OP_STORE,  32'h5555_5555, 32'hAAAA_AAAA, 1, 1'b0, 32'h0000_0000);
      add_row(mtfc_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1, 1'b0, 32'h0000_0000);
      add_row(mtfc_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1, 1'b0, 32'h0000_0000);
      // recency moves, checked by the model
      add_row(mtfc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_STORE,  32'h0000_0001, 32'h8000_0000, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_STORE,  32'h8000_0000, 32'h0000_0001, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_LOOKUP, 32'h5555_5555, 32'h0000_0000, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_STORE,  32'h0000_0000, 32'h0000_0000, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 0, 1'b0, '0);
      add_row(mtfc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      req_idle_pct = 10;
      rsp_idle_pct = 87;
      foreach (probe_table[i]) send_beat(probe_table[i].req, probe_table[i].typed,
                                         probe_table[i].want);
      flood_left = CACHE_DEPTH + 2;
      for (i = 0; i < 220; i++) send_beat(random_req(), 1'b0, '0);

      // sender holds until every result is back
      wait_drained();

      // roles swapped
      req_idle_pct = 87;
      rsp_idle_pct = 10;
      @(posedge clock);
      for (i = 0; i < 220; i++) send_beat(random_req(), 1'b0, '0);

      // long receiver hold while the sender keeps pushing beats
      req_valid    <= 1'b0;
      hold_ask     <= 1'b1;
      req_idle_pct = 0;
      @(posedge clock);
      hold_ask <= 1'b0;
      for (i = 0; i < 12; i++) send_beat(random_req(), 1'b0, '0);

      // no idling on either side
      rsp_idle_pct = 0;
      for (i = 0; i < 240; i++) send_beat(random_req(), 1'b0, '0);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d request beats and checked %0d results: %0d hits, %0d evictions.",
               beats_sent, results_seen, hits_seen, evictions);
      $display("Phases: directed table, two skewed stall mixes, long output hold, full rate.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
